/* design/irpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpc_pkg
// Shared types, codes and constants of the infrared pulse capture block.
// ----------------------------------------------------------------------------
package irpc_pkg;

  localparam int BUFFER_ENTRIES_DEF = 128;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // register indexes on the configuration port
  localparam logic [1:0] REG_GAP_MIN    = 2'd0;
  localparam logic [1:0] REG_GAP_END    = 2'd1;
  localparam logic [1:0] REG_MARK_LEVEL = 2'd2;

  localparam logic [15:0] GAP_MIN_RST   = 16'd100;
  localparam logic [15:0] GAP_END_RST   = 16'd500;
  localparam logic        MARK_LEVEL_RST = 1'b0;

  localparam logic [15:0] TICK_MAX  = 16'hFFFF;
  localparam logic [15:0] GAP_CLAMP = 16'h00FF;

  // receiver phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MARK  = 2'd1;
  localparam logic [1:0] PH_SPACE = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_DURATION = 2'd0;
  localparam logic [1:0] KIND_LONG_SPACE = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;

  // input selector
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic [15:0] gap_min_ticks;
    logic [15:0] gap_end_ticks;
    logic        mark_level;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] tick_count;
    logic [7:0]  entry_count;
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  position;
    logic [15:0] duration;
    logic [7:0]  entry_total;
  } result_t;

endpackage

/* design/irpc_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpc_cfg_regs
// APB register file holding gap thresholds and the mark polarity.
// ----------------------------------------------------------------------------
module irpc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [irpc_pkg::DATA_W-1:0]   pwdata,
  output logic [irpc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output irpc_pkg::cfg_t                cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_min_ticks <= irpc_pkg::GAP_MIN_RST;
      cfg.gap_end_ticks <= irpc_pkg::GAP_END_RST;
      cfg.mark_level    <= irpc_pkg::MARK_LEVEL_RST;
    end else if (wr_en) begin
      case (reg_index)
        irpc_pkg::REG_GAP_MIN:    cfg.gap_min_ticks <= pwdata[15:0];
        irpc_pkg::REG_GAP_END:    cfg.gap_end_ticks <= pwdata[15:0];
        irpc_pkg::REG_MARK_LEVEL: cfg.mark_level    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      irpc_pkg::REG_GAP_MIN:    prdata = {16'd0, cfg.gap_min_ticks};
      irpc_pkg::REG_GAP_END:    prdata = {16'd0, cfg.gap_end_ticks};
      irpc_pkg::REG_MARK_LEVEL: prdata = {31'd0, cfg.mark_level};
      default:                  prdata = '0;
    endcase
  end

endmodule

/* design/irpc_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpc_step
// Next-state and result logic for one sample tick or clear word.
// ----------------------------------------------------------------------------
module irpc_step #(
  parameter int BUFFER_ENTRIES = irpc_pkg::BUFFER_ENTRIES_DEF
) (
  input  irpc_pkg::cfg_t     cfg,
  input  irpc_pkg::state_t   cur,
  input  logic               action,
  input  logic               line_level,
  output irpc_pkg::state_t   nxt,
  output logic               res_valid,
  output irpc_pkg::result_t  res
);

  localparam logic [7:0] FULL_COUNT = 8'(BUFFER_ENTRIES);

  logic        is_mark;
  logic [15:0] tick_inc;
  logic [15:0] gap_len;

  assign is_mark  = (line_level == cfg.mark_level);
  assign tick_inc = (cur.tick_count != irpc_pkg::TICK_MAX) ?
                    cur.tick_count + 16'd1 : cur.tick_count;
  assign gap_len  = (tick_inc >= irpc_pkg::GAP_CLAMP) ? irpc_pkg::GAP_CLAMP : tick_inc;

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    if (action == irpc_pkg::ACT_CLEAR) begin
      nxt.phase       = irpc_pkg::PH_IDLE;
      nxt.entry_count = 8'd0;
    end else begin
      nxt.tick_count = tick_inc;
      // full buffer forces the stopped phase, reported once
      if (cur.entry_count >= FULL_COUNT) begin
        if (cur.phase != irpc_pkg::PH_STOP) begin
          res_valid       = 1'b1;
          res.kind        = irpc_pkg::KIND_OVERFLOW;
          res.duration    = tick_inc;
          res.entry_total = cur.entry_count;
        end
        nxt.phase = irpc_pkg::PH_STOP;
      end
      case (nxt.phase)
        irpc_pkg::PH_IDLE: begin
          if (is_mark) begin
            nxt.tick_count = 16'd0;
            if (tick_inc >= cfg.gap_min_ticks) begin
              res_valid       = 1'b1;
              res.kind        = irpc_pkg::KIND_DURATION;
              res.position    = 7'd0;
              res.duration    = gap_len;
              res.entry_total = 8'd1;
              nxt.entry_count = 8'd1;
              nxt.phase       = irpc_pkg::PH_MARK;
            end
          end
        end
        irpc_pkg::PH_MARK, irpc_pkg::PH_SPACE: begin
          if (is_mark == (nxt.phase == irpc_pkg::PH_SPACE)) begin
            res_valid       = 1'b1;
            res.kind        = irpc_pkg::KIND_DURATION;
            res.position    = cur.entry_count[6:0];
            res.duration    = tick_inc;
            res.entry_total = cur.entry_count + 8'd1;
            nxt.entry_count = cur.entry_count + 8'd1;
            nxt.tick_count  = 16'd0;
            nxt.phase       = (nxt.phase == irpc_pkg::PH_MARK) ?
                              irpc_pkg::PH_SPACE : irpc_pkg::PH_MARK;
          end else if ((nxt.phase == irpc_pkg::PH_SPACE) &&
                       (tick_inc > cfg.gap_end_ticks)) begin
            res_valid       = 1'b1;
            res.kind        = irpc_pkg::KIND_LONG_SPACE;
            res.duration    = tick_inc;
            res.entry_total = cur.entry_count;
            nxt.phase       = irpc_pkg::PH_STOP;
          end
        end
        default: begin
          if (is_mark) begin
            nxt.tick_count = 16'd0;
          end
        end
      endcase
    end
  end

endmodule

/* design/ir_pulse_capture.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_capture
// Raw mark/space length capture for an infrared receiver line.
// ----------------------------------------------------------------------------
// Each input word is one sample tick (tuser = 0, tdata[0] = line level) or a
// clear that re-arms the receiver (tuser = 1). After a long enough idle gap
// the block emits the gap length (clamped to 255) and then every mark and
// space length with its buffer position. A long space ends the frame with
// kind 1, a full buffer with kind 2; the block then waits for a clear.
// Output word: tuser = kind, tdata = position, duration, entry total.
// One word is accepted per cycle while s_tready is high; a result appears
// on the output register the cycle after its input word is accepted, and
// waits there in the single result register until it is taken.
// If the receiver stalls while a result is held, s_tready drops until it is
// taken; ticks that give no result still pass while the register is free.
// Synchronous reset sets idle phase, zero counts, default thresholds and an
// empty output register. Registers sit on an APB port at 0x0, 0x4, 0x8.
// ----------------------------------------------------------------------------
module ir_pulse_capture #(
  parameter int BUFFER_ENTRIES = irpc_pkg::BUFFER_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [irpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [irpc_pkg::DATA_W-1:0]  pwdata,
  output logic [irpc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [0] line_level, [7:1] zero
  input  logic                         s_tuser,   // [0] action
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata,   // [6:0] position, [22:7] duration,
                                                  // [30:23] entry_total, [31] zero
  output logic [1:0]                   m_tuser    // [1:0] kind
);

  irpc_pkg::cfg_t    cfg;
  irpc_pkg::state_t  cur;
  irpc_pkg::state_t  cur_next;
  irpc_pkg::result_t res;
  irpc_pkg::result_t out_res;
  logic              res_valid;
  logic              in_fire;

  irpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  irpc_step #(
    .BUFFER_ENTRIES (BUFFER_ENTRIES)
  ) u_step (
    .cfg        (cfg),
    .cur        (cur),
    .action     (s_tuser),
    .line_level (s_tdata[0]),
    .nxt        (cur_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.phase       <= irpc_pkg::PH_IDLE;
      cur.tick_count  <= 16'd0;
      cur.entry_count <= 8'd0;
    end else if (in_fire) begin
      cur <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tdata = {1'b0, out_res.entry_total, out_res.duration, out_res.position};

  localparam logic [7:0] FULL_COUNT = 8'(BUFFER_ENTRIES);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cur.entry_count <= FULL_COUNT)
    else $error("entry count beyond buffer size");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (cur.phase == irpc_pkg::PH_IDLE) |-> (cur.entry_count == 8'd0))
    else $error("idle phase with entries recorded");

  a_clear_rearms: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser == irpc_pkg::ACT_CLEAR) |=>
      (cur.phase == irpc_pkg::PH_IDLE && cur.entry_count == 8'd0 && !m_tvalid))
    else $error("clear did not re-arm receiver");

  a_position_total: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == irpc_pkg::KIND_DURATION) |->
      (out_res.position == 7'(out_res.entry_total - 8'd1)))
    else $error("duration position disagrees with entry total");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == irpc_pkg::KIND_DURATION ||
                  m_tuser == irpc_pkg::KIND_LONG_SPACE ||
                  m_tuser == irpc_pkg::KIND_OVERFLOW))
    else $error("illegal result kind");

endmodule

/* tb/tb_ir_pulse_capture.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ir_pulse_capture
// Self-checking bench for the infrared mark/space capture block.
// ----------------------------------------------------------------------------
// Sample ticks and clears go in on the slave stream. An in-bench copy of the
// receiver predicts every duration, long-space and overflow word. Results on
// the master stream are checked field by field against the oldest prediction.
// Directed frames run first. Then comes a full-buffer frame whose leading gap
// lies above the clamp. Last are random frames under several threshold and
// polarity settings, with noise and broken frames mixed in. Both stream sides
// stall at random. Thresholds are written on the APB port only after the
// stream stops and every pending word has come out.
// ----------------------------------------------------------------------------
module tb_ir_pulse_capture;

  localparam int BUF_ENTRIES = irpc_pkg::BUFFER_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [irpc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [irpc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [irpc_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata = '0;   // [0] line_level, [7:1] zero
  logic                          s_tuser = 1'b0; // [0] action
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [31:0]                   m_tdata;        // [6:0] position, [22:7] duration,
                                                 // [30:23] entry_total, [31] zero
  logic [1:0]                    m_tuser;        // [1:0] kind

  // receiver copy used for prediction
  logic [1:0]  rx_phase = irpc_pkg::PH_IDLE;
  logic [15:0] rx_ticks = '0;
  logic [7:0]  rx_entries = '0;
  logic [15:0] cfg_gap_min = irpc_pkg::GAP_MIN_RST;
  logic [15:0] cfg_gap_end = irpc_pkg::GAP_END_RST;
  logic        cfg_mark_level = irpc_pkg::MARK_LEVEL_RST;

  irpc_pkg::result_t results_due[$];
  irpc_pkg::result_t oldest_due;
  int      errors = 0;
  int      items_sent = 0;
  int      cycle_count = 0;
  bit      no_gaps = 1'b0;

  ir_pulse_capture #(.BUFFER_ENTRIES(BUF_ENTRIES)) u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ir_pulse_capture: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (no_gaps) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 14);
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void note_result(input logic [1:0] kind, input logic [6:0] pos,
                                      input logic [15:0] dur);
    irpc_pkg::result_t r;
    r.kind = kind;
    r.position = pos;
    r.duration = dur;
    r.entry_total = rx_entries;
    results_due.push_back(r);
  endfunction

  function automatic void record_entry(input logic [15:0] dur, input logic [1:0] next_ph);
    logic [6:0] pos;
    pos = rx_entries[6:0];
    rx_entries = rx_entries + 8'd1;
    rx_ticks = '0;
    rx_phase = next_ph;
    note_result(irpc_pkg::KIND_DURATION, pos, dur);
  endfunction

  function automatic void capture_step(input logic act, input logic lvl);
    logic is_mark;
    is_mark = (lvl == cfg_mark_level);
    if (act == irpc_pkg::ACT_CLEAR) begin
      rx_phase = irpc_pkg::PH_IDLE;
      rx_entries = '0;
    end else begin
      if (rx_ticks != irpc_pkg::TICK_MAX) rx_ticks = rx_ticks + 16'd1;
      // a full buffer stops the frame before the tick itself is looked at
      if (rx_entries >= BUF_ENTRIES) begin
        if (rx_phase != irpc_pkg::PH_STOP) begin
          note_result(irpc_pkg::KIND_OVERFLOW, '0, rx_ticks);
        end
        rx_phase = irpc_pkg::PH_STOP;
      end
      case (rx_phase)
        irpc_pkg::PH_IDLE: begin
          if (is_mark) begin
            if (rx_ticks < cfg_gap_min) begin
              rx_ticks = '0;
            end else begin
              rx_entries = '0;
              record_entry((rx_ticks >= irpc_pkg::GAP_CLAMP) ? irpc_pkg::GAP_CLAMP
                                                              : rx_ticks,
                           irpc_pkg::PH_MARK);
            end
          end
        end
        irpc_pkg::PH_MARK: begin
          if (!is_mark) record_entry(rx_ticks, irpc_pkg::PH_SPACE);
        end
        irpc_pkg::PH_SPACE: begin
          if (is_mark) begin
            record_entry(rx_ticks, irpc_pkg::PH_MARK);
          end else if (rx_ticks > cfg_gap_end) begin
            rx_phase = irpc_pkg::PH_STOP;
            note_result(irpc_pkg::KIND_LONG_SPACE, '0, rx_ticks);
          end
        end
        default: begin
          if (is_mark) rx_ticks = '0;
        end
      endcase
    end
  endfunction

  // ------------------------------------------------------------------ checker

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected word kind %0d tdata %h", $time, m_tuser, m_tdata);
        errors++;
      end else begin
        oldest_due = results_due.pop_front();
        if (m_tuser !== oldest_due.kind) begin
          $display("%0t: kind expected %0d got %0d", $time, oldest_due.kind, m_tuser);
          errors++;
        end
        if (m_tdata[6:0] !== oldest_due.position) begin
          $display("%0t: position expected %0d got %0d", $time, oldest_due.position,
                   m_tdata[6:0]);
          errors++;
        end
        if (m_tdata[22:7] !== oldest_due.duration) begin
          $display("%0t: duration expected %0d got %0d", $time, oldest_due.duration,
                   m_tdata[22:7]);
          errors++;
        end
        if (m_tdata[30:23] !== oldest_due.entry_total) begin
          $display("%0t: entry_total expected %0d got %0d", $time,
                   oldest_due.entry_total, m_tdata[30:23]);
          errors++;
        end
      end
    end
  end

  // ------------------------------------------------------------ drive helpers

  task automatic send_word(input logic act, input logic lvl);
    while (!no_gaps && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {7'd0, lvl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    capture_step(act, lvl);
    items_sent++;
  endtask

  task automatic hold_level(input bit mark, input int n);
    repeat (n) send_word(irpc_pkg::ACT_TICK, mark ? cfg_mark_level : ~cfg_mark_level);
  endtask

  task automatic send_clear();
    send_word(irpc_pkg::ACT_CLEAR, 1'($urandom_range(1)));
  endtask

  // stop the stream and let every pending word come out
  task automatic settle();
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [15:0] gap_min, input logic [15:0] gap_end,
                                input logic mark_lvl);
    settle();
    reg_write(irpc_pkg::REG_GAP_MIN, {16'd0, gap_min});
    reg_write(irpc_pkg::REG_GAP_END, {16'd0, gap_end});
    reg_write(irpc_pkg::REG_MARK_LEVEL, {31'd0, mark_lvl});
    cfg_gap_min = gap_min;
    cfg_gap_end = gap_end;
    cfg_mark_level = mark_lvl;
  endtask

  // mostly well-formed frames with random lengths, plus noise and broken frames
  task automatic run_frames(input int budget);
    int start;
    int gap;
    int pulses;
    int sp_max;
    start = items_sent;
    sp_max = (cfg_gap_end > 8) ? 8 : ((cfg_gap_end == 0) ? 1 : int'(cfg_gap_end));
    while (items_sent - start < budget) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 8)) begin
          send_word(($urandom_range(9) == 0) ? irpc_pkg::ACT_CLEAR : irpc_pkg::ACT_TICK,
                    1'($urandom_range(1)));
        end
      end else begin
        if ($urandom_range(3) != 0) send_clear();
        gap = ($urandom_range(4) == 0) ? int'(cfg_gap_min) / 2
                                         : int'(cfg_gap_min) + $urandom_range(0, 3);
        hold_level(1'b0, gap);
        pulses = $urandom_range(1, 12);
        for (int i = 0; i < pulses; i++) begin
          hold_level(1'b1, $urandom_range(1, 5));
          if (i != pulses - 1) begin
            // now and then a space exactly at the end threshold
            if (cfg_gap_end <= 16 && cfg_gap_end != 0 && $urandom_range(5) == 0) begin
              hold_level(1'b0, cfg_gap_end);
            end else begin
              hold_level(1'b0, $urandom_range(1, sp_max));
            end
          end
        end
        // a broken frame is left open and re-armed by a later clear
        if ($urandom_range(3) != 0) hold_level(1'b0, int'(cfg_gap_end) + $urandom_range(1, 3));
      end
    end
  endtask

  // ------------------------------------------------------------------- tests

  task automatic test_directed();
    set_thresholds(16'd3, 16'd4, 1'b0);
    send_clear();
    hold_level(1'b1, 1);   // mark too soon: gap rejected
    hold_level(1'b0, 2);
    hold_level(1'b1, 1);   // gap accepted as entry 0
    hold_level(1'b1, 2);
    hold_level(1'b0, 1);
    hold_level(1'b0, 3);   // space right at the end threshold
    hold_level(1'b1, 1);
    hold_level(1'b0, 5);   // space not yet long enough to end the frame
    hold_level(1'b1, 1);   // mark ends the space as a normal entry
    hold_level(1'b0, 2);
    send_clear();
    send_clear();
    hold_level(1'b1, 1);
    hold_level(1'b0, 1);
    send_clear();
  endtask

  task automatic test_full_buffer();
    set_thresholds(16'd0, irpc_pkg::TICK_MAX, 1'b0);
    send_clear();
    hold_level(1'b0, 300);  // leading gap above the clamp
    hold_level(1'b1, 1);
    for (int i = 0; i < 70; i++) begin
      hold_level(1'b1, $urandom_range(1, 2));
      hold_level(1'b0, $urandom_range(1, 2));
    end
    hold_level(1'b1, 3);
    send_clear();
    hold_level(1'b1, 2);
  endtask

  task automatic test_random_frames();
    set_thresholds(irpc_pkg::GAP_MIN_RST, irpc_pkg::GAP_END_RST,
                   irpc_pkg::MARK_LEVEL_RST);
    run_frames(250);
    set_thresholds(16'd0, 16'd0, 1'b1);
    run_frames(150);
    for (int p = 0; p < 4; p++) begin
      set_thresholds(16'($urandom_range(1, 12)), 16'($urandom_range(2, 16)),
                     1'($urandom_range(1)));
      no_gaps = (p == 2);
      run_frames(175);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_buffer();
    test_random_frames();
    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("ir_pulse_capture: match");
    end else begin
      $display("ir_pulse_capture: mismatch");
    end
    $finish;
  end

endmodule
